// ===== rtl/sgh_pkg.sv =====
// Shared types, constants and helpers for the stencil gradient/Hessian block.
// Used by sgh_ctrl, sgh_datapath and the top level stencil_gradient_hessian.
package sgh_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int FRAC_W     = 16;
  localparam int COL_W      = 6;
  localparam int ROW_W      = 6;
  localparam int PLANE_W    = 16;
  localparam int SIZE_XY_W  = 7;
  localparam int MAX_ROW    = 64;
  localparam int MAX_ROWS_C = 64;
  localparam int MEM_DEPTH  = 3 * MAX_ROW * MAX_ROWS_C;
  localparam int MEM_AW     = 2 + ROW_W + COL_W;
  localparam int NB_COUNT   = 19;
  localparam int NB_W       = 5;
  localparam int TERM_COUNT = 9;
  localparam int TERM_W     = 4;
  localparam int DIFF_W     = 36;
  localparam int MAG_W      = 35;
  localparam int ACC_W      = 100;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd5;

  localparam logic [NB_W-1:0]   NB_LAST   = 5'(NB_COUNT);
  localparam logic [TERM_W-1:0] TERM_LAST = 4'(TERM_COUNT - 1);

  // controller to datapath
  typedef struct packed {
    logic              accept;
    logic              rd_issue;
    logic [NB_W-1:0]   rd_idx;
    logic              pre;
    logic              mul;
    logic [1:0]        step;
    logic              rnd;
    logic [TERM_W-1:0] term;
    logic              load;
  } sgh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic interior;
    logic out_busy;
  } sgh_status_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_PRE   = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_ROUND = 7'b0100000,
    S_LOAD  = 7'b1000000
  } sgh_state_t;

  // Neighbour offsets as {dz,dy,dx}, each code 0:-1, 1:0, 2:+1.
  // Order: centre, x-/x+, y-/y+, z-/z+, then the xy, xz, yz corners as
  // (--), (++), (+-), (-+).
  function automatic logic [5:0] nb_code(logic [NB_W-1:0] idx);
    logic [5:0] c;
    case (idx)
      5'd0:    c = {2'd1, 2'd1, 2'd1};
      5'd1:    c = {2'd1, 2'd1, 2'd0};
      5'd2:    c = {2'd1, 2'd1, 2'd2};
      5'd3:    c = {2'd1, 2'd0, 2'd1};
      5'd4:    c = {2'd1, 2'd2, 2'd1};
      5'd5:    c = {2'd0, 2'd1, 2'd1};
      5'd6:    c = {2'd2, 2'd1, 2'd1};
      5'd7:    c = {2'd1, 2'd0, 2'd0};
      5'd8:    c = {2'd1, 2'd2, 2'd2};
      5'd9:    c = {2'd1, 2'd0, 2'd2};
      5'd10:   c = {2'd1, 2'd2, 2'd0};
      5'd11:   c = {2'd0, 2'd1, 2'd0};
      5'd12:   c = {2'd2, 2'd1, 2'd2};
      5'd13:   c = {2'd0, 2'd1, 2'd2};
      5'd14:   c = {2'd2, 2'd1, 2'd0};
      5'd15:   c = {2'd0, 2'd0, 2'd1};
      5'd16:   c = {2'd2, 2'd2, 2'd1};
      5'd17:   c = {2'd0, 2'd2, 2'd1};
      5'd18:   c = {2'd2, 2'd0, 2'd1};
      default: c = {2'd1, 2'd1, 2'd1};
    endcase
    return c;
  endfunction

  // (s + k) mod 3 for a plane slot s in 0..2 and k in 0..2
  function automatic logic [1:0] slot_add(logic [1:0] s, logic [1:0] k);
    logic [2:0] t;
    t = 3'(s) + 3'(k);
    return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
  endfunction

endpackage

// ===== rtl/sgh_ctrl.sv =====
// Sequencer for the stencil block: accept, neighbour reads, per-term multiply.
// Depends on sgh_pkg; drives sgh_datapath through sgh_cmd_t.
module sgh_ctrl
  import sgh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sgh_status_t st,
  output sgh_cmd_t    cmd
);

  sgh_state_t        state_r, state_nxt;
  logic [NB_W-1:0]   cnt_r, cnt_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic [1:0]        step_r, step_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    term_nxt  = term_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.rd_idx = cnt_r;
    cmd.term   = term_r;
    cmd.step   = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.interior) begin
            state_nxt = S_READ;
            cnt_nxt   = '0;
          end
        end
      end
      S_READ: begin
        if (cnt_r == NB_LAST) begin
          state_nxt = S_PRE;
          term_nxt  = '0;
        end else begin
          cmd.rd_issue = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
        end
      end
      S_PRE: begin
        cmd.pre   = 1'b1;
        step_nxt  = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (step_r == 2'd3) state_nxt = S_DRAIN;
        else step_nxt = step_r + 1'b1;
      end
      S_DRAIN: state_nxt = S_ROUND;
      S_ROUND: begin
        cmd.rnd = 1'b1;
        if (term_r == TERM_LAST) begin
          state_nxt = S_LOAD;
        end else begin
          term_nxt  = term_r + 1'b1;
          state_nxt = S_PRE;
        end
      end
      S_LOAD: begin
        if (!st.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      term_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      term_r  <= term_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== rtl/sgh_datapath.sv =====
// Datapath: config registers, position counters, plane history memory,
// neighbour registers, shared 32x32 multiplier, rounding and output registers.
// Depends on sgh_pkg; commanded by sgh_ctrl.
module sgh_datapath
  import sgh_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  sgh_cmd_t                    cmd,
  output sgh_status_t                 st,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [SAMPLE_W-1:0]  in_sample_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_grad_x,
  output logic signed [SAMPLE_W-1:0]  out_grad_y,
  output logic signed [SAMPLE_W-1:0]  out_grad_z,
  output logic signed [SAMPLE_W-1:0]  out_hess_xx,
  output logic signed [SAMPLE_W-1:0]  out_hess_yy,
  output logic signed [SAMPLE_W-1:0]  out_hess_zz,
  output logic signed [SAMPLE_W-1:0]  out_hess_xy,
  output logic signed [SAMPLE_W-1:0]  out_hess_xz,
  output logic signed [SAMPLE_W-1:0]  out_hess_yz,
  output logic [COL_W-1:0]            out_point_x,
  output logic [ROW_W-1:0]            out_point_y,
  output logic [PLANE_W-1:0]          out_point_z
);

  // configuration
  logic [31:0]          inv_x_r, inv_y_r, inv_z_r;
  logic [SIZE_XY_W-1:0] size_x_r, size_y_r;
  logic [PLANE_W-1:0]   size_z_r;
  logic [6:0]           v7;
  logic [PLANE_W-1:0]   v16;
  logic                 size_we;

  // position of the next sample
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [PLANE_W-1:0] plane_r;
  logic [1:0]         slot_r;

  // latched stencil base (position of the newest sample)
  logic [COL_W-1:0]   bcol_r;
  logic [ROW_W-1:0]   brow_r;
  logic [1:0]         bslot_r;
  logic [PLANE_W-1:0] cz_r;
  logic [COL_W-1:0]   cx_r;
  logic [ROW_W-1:0]   cy_r;

  logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic signed [SAMPLE_W-1:0] mem_q_r;
  logic [MEM_AW-1:0]          wr_addr, rd_addr;
  logic                       rd_pend_r;
  logic [NB_W-1:0]            rd_idx_r;
  logic [5:0]                 code;

  logic signed [SAMPLE_W-1:0] nb_r [NB_COUNT];
  logic signed [DIFF_W-1:0]   e [NB_COUNT];
  logic signed [DIFF_W-1:0]   diff;
  logic [31:0]                mi, mj;
  logic [MAG_W-1:0]           mag_r;
  logic                       neg_r;
  logic [63:0]                prod_r;
  logic [63:0]                pp_r;
  logic [1:0]                 pp_sh_r;
  logic                       pp_vld_r;
  logic [31:0]                ma, mb;
  logic [ACC_W-1:0]           acc_r, pp_ext;

  logic [ACC_W-1:0]           rsum, q;
  logic [31:0]                limit, res_mag, res;
  logic signed [SAMPLE_W-1:0] res_r [TERM_COUNT];
  logic                       out_valid_r;

  assign v7      = cfg_data[6:0];
  assign v16     = cfg_data[15:0];
  assign size_we = cfg_we && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
                              cfg_index == REG_SIZE_Z);

  assign st.interior = (col_r >= 6'd2) && (row_r >= 6'd2) && (plane_r >= 16'd2);
  assign st.out_busy = out_valid_r && !out_ready;

  // config registers, with size clamping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_x_r  <= 32'd65536;
      inv_y_r  <= 32'd65536;
      inv_z_r  <= 32'd65536;
      size_x_r <= 7'd64;
      size_y_r <= 7'd64;
      size_z_r <= 16'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INV_X:  inv_x_r <= cfg_data;
        REG_INV_Y:  inv_y_r <= cfg_data;
        REG_INV_Z:  inv_z_r <= cfg_data;
        REG_SIZE_X: size_x_r <= (v7 < 7'd3) ? 7'd3 : ((v7 > 7'(MAX_ROW)) ? 7'(MAX_ROW) : v7);
        REG_SIZE_Y: size_y_r <= (v7 < 7'd3) ? 7'd3 :
                                ((v7 > 7'(MAX_ROWS_C)) ? 7'(MAX_ROWS_C) : v7);
        REG_SIZE_Z: size_z_r <= (v16 < 16'd3) ? 16'd3 : v16;
        default: ;
      endcase
    end
  end

  // raster counters
  always_ff @(posedge clk) begin
    if (!rst_n || size_we) begin
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
      slot_r  <= '0;
    end else if (cmd.accept) begin
      if (7'(col_r) + 7'd1 >= size_x_r) begin
        col_r <= '0;
        if (7'(row_r) + 7'd1 >= size_y_r) begin
          row_r  <= '0;
          slot_r <= slot_add(slot_r, 2'd1);
          if (17'(plane_r) + 17'd1 >= 17'(size_z_r)) plane_r <= '0;
          else plane_r <= plane_r + 1'b1;
        end else begin
          row_r <= row_r + 1'b1;
        end
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // stencil base and centre point
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bcol_r  <= col_r;
      brow_r  <= row_r;
      bslot_r <= slot_r;
      cx_r    <= col_r - 1'b1;
      cy_r    <= row_r - 1'b1;
      cz_r    <= plane_r - 1'b1;
    end
  end

  // history memory: write on accept, one neighbour read per cycle in the read phase
  assign wr_addr = {slot_r, row_r, col_r};
  assign code    = nb_code(cmd.rd_idx);
  always_comb begin
    logic [1:0] s;
    case (code[5:4])
      2'd0:    s = slot_add(bslot_r, 2'd1);
      2'd1:    s = slot_add(bslot_r, 2'd2);
      default: s = bslot_r;
    endcase
    rd_addr = {s, brow_r + 6'(code[3:2]) - 6'd2, bcol_r + 6'(code[1:0]) - 6'd2};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) mem[wr_addr] <= in_sample_value;
    if (cmd.rd_issue) mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_pend_r <= 1'b0;
    else rd_pend_r <= cmd.rd_issue;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rd_idx_r <= cmd.rd_idx;
    if (rd_pend_r) nb_r[rd_idx_r] <= mem_q_r;
  end

  // stencil sums and multiplier operands per term
  always_comb begin
    for (int i = 0; i < NB_COUNT; i++) e[i] = DIFF_W'(nb_r[i]);
    case (cmd.term)
      4'd0: begin diff = e[2] - e[1]; mi = inv_x_r; mj = 32'd1; end
      4'd1: begin diff = e[4] - e[3]; mi = inv_y_r; mj = 32'd1; end
      4'd2: begin diff = e[6] - e[5]; mi = inv_z_r; mj = 32'd1; end
      4'd3: begin diff = e[1] - (e[0] <<< 1) + e[2]; mi = inv_x_r; mj = inv_x_r; end
      4'd4: begin diff = e[3] - (e[0] <<< 1) + e[4]; mi = inv_y_r; mj = inv_y_r; end
      4'd5: begin diff = e[5] - (e[0] <<< 1) + e[6]; mi = inv_z_r; mj = inv_z_r; end
      4'd6: begin diff = e[7] + e[8] - e[9] - e[10]; mi = inv_x_r; mj = inv_y_r; end
      4'd7: begin diff = e[11] + e[12] - e[13] - e[14]; mi = inv_x_r; mj = inv_z_r; end
      4'd8: begin diff = e[15] + e[16] - e[17] - e[18]; mi = inv_y_r; mj = inv_z_r; end
      default: begin diff = '0; mi = '0; mj = '0; end
    endcase
  end

  // partial product operand select: magnitude halves times scale halves
  always_comb begin
    case (cmd.step)
      2'd0:    begin ma = mag_r[31:0];          mb = prod_r[31:0];  end
      2'd1:    begin ma = mag_r[31:0];          mb = prod_r[63:32]; end
      2'd2:    begin ma = 32'(mag_r[MAG_W-1:32]); mb = prod_r[31:0];  end
      default: begin ma = 32'(mag_r[MAG_W-1:32]); mb = prod_r[63:32]; end
    endcase
  end

  // shared multiplier and accumulator
  always_ff @(posedge clk) begin
    if (cmd.pre) begin
      prod_r <= 64'(mi) * 64'(mj);
      neg_r  <= diff[DIFF_W-1];
      mag_r  <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    end
    if (cmd.mul) begin
      pp_r    <= 64'(ma) * 64'(mb);
      pp_sh_r <= (cmd.step == 2'd0) ? 2'd0 : ((cmd.step == 2'd3) ? 2'd2 : 2'd1);
    end
  end

  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_ext = ACC_W'(pp_r);
      2'd1:    pp_ext = ACC_W'(pp_r) << 32;
      default: pp_ext = ACC_W'(pp_r) << 64;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pp_vld_r <= 1'b0;
    else pp_vld_r <= cmd.mul;
  end

  always_ff @(posedge clk) begin
    if (cmd.pre) acc_r <= '0;
    else if (pp_vld_r) acc_r <= acc_r + pp_ext;
  end

  // round half away from zero, saturate, restore sign
  always_comb begin
    if (cmd.term < 4'd3) begin
      rsum = acc_r + (ACC_W'(1) << FRAC_W);
      q    = rsum >> (FRAC_W + 1);
    end else if (cmd.term < 4'd6) begin
      rsum = acc_r + (ACC_W'(1) << (2 * FRAC_W - 1));
      q    = rsum >> (2 * FRAC_W);
    end else begin
      rsum = acc_r + (ACC_W'(1) << (2 * FRAC_W + 1));
      q    = rsum >> (2 * FRAC_W + 2);
    end
    limit   = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    res_mag = (q > ACC_W'(limit)) ? limit : q[31:0];
    res     = neg_r ? (32'd0 - res_mag) : res_mag;
  end

  always_ff @(posedge clk) begin
    if (cmd.rnd) res_r[cmd.term] <= res;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_grad_x  <= res_r[0];
      out_grad_y  <= res_r[1];
      out_grad_z  <= res_r[2];
      out_hess_xx <= res_r[3];
      out_hess_yy <= res_r[4];
      out_hess_zz <= res_r[5];
      out_hess_xy <= res_r[6];
      out_hess_xz <= res_r[7];
      out_hess_yz <= res_r[8];
      out_point_x <= cx_r;
      out_point_y <= cy_r;
      out_point_z <= cz_r;
    end
  end

  assign out_valid = out_valid_r;

  // a waiting result is never overwritten
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken beat");

  // memory port is never asked to write and deliver a read in the same cycle
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (!cmd.rd_issue && !rd_pend_r))
    else $error("history write collides with neighbour read");

  // multiply steps only run after the scale product is ready
  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul && cmd.step == 2'd0) |-> $past(cmd.pre))
    else $error("multiply step without scale product");

endmodule

// ===== rtl/stencil_gradient_hessian.sv =====
// Top level of the 3D central-difference gradient/Hessian block.
// Depends on sgh_pkg, sgh_ctrl and sgh_datapath.
//
// Use:
//   in_*  : one grid sample per beat, signed Q16.16, raster order x fastest.
//   out_* : one beat per interior point: gradient, Hessian diagonal and
//           mixed terms, all Q16.16 rounded and saturated, plus the centre
//           point indices. Boundary samples give no beat.
//   cfg_* : register writes (index 0..5: inv spacing x/y/z, size x/y/z);
//           cfg_ready is always high. Writing a size restarts the raster.
// Sequence:
//   A boundary sample is accepted in the idle state. An interior sample runs
//   19 neighbour reads from the single-port history memory, then 9 terms
//   on the shared 32x32 multiplier (scale product, four partial products,
//   accumulate, round), then the load into the output register. in_ready
//   is high only between samples.
// Reset (rst_n low, synchronous): registers return to defaults, the raster
//   restarts and no beat is pending. History needs no clearing.
// Stall: a finished result waits in the output register; a new sample may be
//   accepted meanwhile, and its own result waits until that beat is taken.
module stencil_gradient_hessian
  import sgh_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_grad_x,
  output logic signed [SAMPLE_W-1:0]  out_grad_y,
  output logic signed [SAMPLE_W-1:0]  out_grad_z,
  output logic signed [SAMPLE_W-1:0]  out_hess_xx,
  output logic signed [SAMPLE_W-1:0]  out_hess_yy,
  output logic signed [SAMPLE_W-1:0]  out_hess_zz,
  output logic signed [SAMPLE_W-1:0]  out_hess_xy,
  output logic signed [SAMPLE_W-1:0]  out_hess_xz,
  output logic signed [SAMPLE_W-1:0]  out_hess_yz,
  output logic [COL_W-1:0]            out_point_x,
  output logic [ROW_W-1:0]            out_point_y,
  output logic [PLANE_W-1:0]          out_point_z,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  sgh_cmd_t    cmd;
  sgh_status_t st;

  assign cfg_ready = 1'b1;

  sgh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  sgh_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_grad_x      (out_grad_x),
    .out_grad_y      (out_grad_y),
    .out_grad_z      (out_grad_z),
    .out_hess_xx     (out_hess_xx),
    .out_hess_yy     (out_hess_yy),
    .out_hess_zz     (out_hess_zz),
    .out_hess_xy     (out_hess_xy),
    .out_hess_xz     (out_hess_xz),
    .out_hess_yz     (out_hess_yz),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_z     (out_point_z)
  );

endmodule
